// File: design/pal_pkg.sv
`timescale 1ns / 1ps

package pal_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int CMD_W        = 3;
  localparam int POS_W        = 6;
  localparam int NUM_W        = 32;
  localparam int NAME_W       = 64;
  localparam int ST_W         = 2;
  localparam int CNT_OUT_W    = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR     = 3'd0,
    CMD_INS_AT    = 3'd1,
    CMD_INS_FRONT = 3'd2,
    CMD_APPEND    = 3'd3,
    CMD_DELETE    = 3'd4,
    CMD_READ      = 3'd5
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CO_KEEP,
    CO_CLEAR,
    CO_INC,
    CO_DEC
  } cnt_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_UP,
    S_UP_DRAIN,
    S_PUT,
    S_RD,
    S_RD_CAP,
    S_DN,
    S_DN_DRAIN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [NUM_W-1:0]  number;
    logic [NAME_W-1:0] name;
  } entry_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic rd_tgt;
    logic cap;
    logic shift_up;
    logic shift_dn;
    logic put;
    logic put_at_count;
    logic fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             bad;
    logic             up_any;
    logic             up_last;
    logic             dn_any;
    logic             dn_last;
  } dp_stat_t;

endpackage

// File: design/pal_ctrl.sv
`timescale 1ns / 1ps

module pal_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pal_pkg::dp_stat_t st,
  output pal_pkg::ctl_cmd_t cmd
);
  import pal_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        unique case (st.cmd)
          CMD_INS_AT:    state_next = (st.full || st.bad) ? S_FIN : S_UP;
          CMD_INS_FRONT: state_next = st.full ? S_FIN : (st.up_any ? S_UP : S_PUT);
          CMD_DELETE,
          CMD_READ:      state_next = st.bad ? S_FIN : S_RD;
          default:       state_next = S_FIN;
        endcase
      end
      S_UP: begin
        if (st.up_last) state_next = S_UP_DRAIN;
      end
      S_UP_DRAIN: state_next = S_PUT;
      S_PUT:      state_next = S_FIN;
      S_RD:       state_next = S_RD_CAP;
      S_RD_CAP: begin
        if (st.cmd == CMD_DELETE && st.dn_any) state_next = S_DN;
        else state_next = S_FIN;
      end
      S_DN: begin
        if (st.dn_last) state_next = S_DN_DRAIN;
      end
      S_DN_DRAIN: state_next = S_FIN;
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (st.cmd == CMD_APPEND && !st.full) begin
          cmd.put          = 1'b1;
          cmd.put_at_count = 1'b1;
        end
      end
      S_UP:     cmd.shift_up = 1'b1;
      S_PUT:    cmd.put = 1'b1;
      S_RD:     cmd.rd_tgt = 1'b1;
      S_RD_CAP: cmd.cap = 1'b1;
      S_DN:     cmd.shift_dn = 1'b1;
      S_FIN:    cmd.fin = out_free;
      default: begin
      end
    endcase
  end

endmodule

// File: design/pal_dpath.sv
`timescale 1ns / 1ps

module pal_dpath #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pal_pkg::ctl_cmd_t                    cmd,
  output pal_pkg::dp_stat_t                    st,
  input  logic [pal_pkg::CMD_W-1:0]            command,
  input  logic [pal_pkg::POS_W-1:0]            position,
  input  logic signed [pal_pkg::NUM_W-1:0]     item_number,
  input  logic [pal_pkg::NAME_W-1:0]           item_name,
  output logic [pal_pkg::ST_W-1:0]             status,
  output logic signed [pal_pkg::NUM_W-1:0]     out_number,
  output logic [pal_pkg::NAME_W-1:0]           out_name,
  output logic [pal_pkg::CNT_OUT_W-1:0]        entry_count
);
  import pal_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  entry_t mem [CAPACITY];

  logic [CMD_W-1:0]  cmd_q;
  logic [POS_W-1:0]  pos_q;
  entry_t            item_q;
  logic [CW-1:0]     tgt;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     ptr;
  cnt_op_t           cnt_op;
  cnt_op_t           cnt_op_next;
  status_t           res_status;
  status_t           res_status_next;
  entry_t            res_entry;
  entry_t            rd_data;
  logic              wr_pend;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [AW-1:0]     waddr;
  entry_t            wdata;

  // status toward the controller
  always_comb begin
    st.cmd     = cmd_q;
    st.full    = (count == CW'(CAPACITY));
    st.bad     = (CMPW'(pos_q) >= CMPW'(count));
    st.up_any  = (count != tgt);
    st.up_last = (ptr == tgt + CW'(1));
    st.dn_any  = ((CW+1)'(tgt) + (CW+1)'(1)) < (CW+1)'(count);
    st.dn_last = ((CW+1)'(ptr) + (CW+1)'(2)) == (CW+1)'(count);
  end

  // command decode
  always_comb begin
    res_status_next = ST_OK;
    cnt_op_next     = CO_KEEP;
    unique case (cmd_q)
      CMD_CLEAR: cnt_op_next = CO_CLEAR;
      CMD_INS_AT: begin
        if (st.full) res_status_next = ST_FULL;
        else if (st.bad) res_status_next = ST_BADPOS;
        else cnt_op_next = CO_INC;
      end
      CMD_INS_FRONT,
      CMD_APPEND: begin
        if (st.full) res_status_next = ST_FULL;
        else cnt_op_next = CO_INC;
      end
      CMD_DELETE: begin
        if (st.bad) res_status_next = ST_BADPOS;
        else cnt_op_next = CO_DEC;
      end
      CMD_READ: begin
        if (st.bad) res_status_next = ST_BADPOS;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (cnt_op)
      CO_CLEAR: count_next = '0;
      CO_INC:   count_next = count + CW'(1);
      CO_DEC:   count_next = count - CW'(1);
      default:  count_next = count;
    endcase
  end

  // memory ports
  always_comb begin
    rd_en   = cmd.rd_tgt || cmd.shift_up || cmd.shift_dn;
    rd_addr = AW'(tgt);
    if (cmd.shift_up) rd_addr = AW'(ptr - CW'(1));
    else if (cmd.shift_dn) rd_addr = AW'(ptr + CW'(1));
    we    = wr_pend || cmd.put;
    waddr = wr_pend ? wr_addr : (cmd.put_at_count ? AW'(count) : AW'(tgt));
    wdata = wr_pend ? rd_data : item_q;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // shift write-back follows its read in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= cmd.shift_up || cmd.shift_dn;
    end
    wr_addr <= AW'(ptr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.fin) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q         <= command;
      pos_q         <= position;
      item_q.number <= item_number;
      item_q.name   <= item_name;
      tgt           <= (command == CMD_INS_FRONT) ? '0 : CW'(position);
    end
    if (cmd.exec) begin
      res_status <= res_status_next;
      cnt_op     <= cnt_op_next;
      res_entry  <= '0;
      ptr        <= (cmd_q == CMD_DELETE) ? tgt : count;
    end
    if (cmd.shift_up) ptr <= ptr - CW'(1);
    if (cmd.shift_dn) ptr <= ptr + CW'(1);
    if (cmd.cap) res_entry <= rd_data;
    if (cmd.fin) begin
      status      <= res_status;
      out_number  <= res_entry.number;
      out_name    <= res_entry.name;
      entry_count <= CNT_OUT_W'(count_next);
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_shift_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (wr_pend && rd_en) |-> (rd_addr != wr_addr))
    else $error("shift read hits pending write address");

  a_put_port_free: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> !wr_pend)
    else $error("item write collides with shift write-back");

  a_fin_no_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> !wr_pend && !rd_en)
    else $error("result taken while memory still busy");
`endif

endmodule

// File: design/positional_array_list_unit.sv
`timescale 1ns / 1ps
// read: exec, memory read, capture, result; clear/append/rejected: exec, result
// insert: entries from position on shift up, then the item is written
// delete: reads the entry, then shifts later entries down; no shift for the last entry
// throughput: one command at a time, bounded by the one-entry-per-cycle shift through
// the single-write, single-read entry memory
// reset: synchronous, clears the entry count and handshake state; entries are not cleared

module positional_array_list_unit #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pal_pkg::CMD_W-1:0]         command,
  input  logic [pal_pkg::POS_W-1:0]         position,
  input  logic signed [pal_pkg::NUM_W-1:0]  item_number,
  input  logic [pal_pkg::NAME_W-1:0]        item_name,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pal_pkg::ST_W-1:0]          status,
  output logic signed [pal_pkg::NUM_W-1:0]  out_number,
  output logic [pal_pkg::NAME_W-1:0]        out_name,
  output logic [pal_pkg::CNT_OUT_W-1:0]     entry_count
);
  import pal_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t dst;

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (dst),
    .cmd       (ctl)
  );

  pal_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (ctl),
    .st          (dst),
    .command     (command),
    .position    (position),
    .item_number (item_number),
    .item_name   (item_name),
    .status      (status),
    .out_number  (out_number),
    .out_name    (out_name),
    .entry_count (entry_count)
  );

endmodule

// File: dv/tb_positional_array_list_unit.sv
`timescale 1ns / 1ps

module tb_positional_array_list_unit;
  import pal_pkg::*;

  localparam int LIST_CAP     = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1500;
  localparam int TAIL_ITEMS   = 150;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 100;

  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BLEND, MIX_NOISE} mix_t;

  typedef struct {
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         pos;
    logic signed [NUM_W-1:0]  number;
    logic [NAME_W-1:0]        name;
  } list_cmd_t;

  typedef struct {
    logic [ST_W-1:0]          status;
    logic signed [NUM_W-1:0]  number;
    logic [NAME_W-1:0]        name;
    logic [CNT_OUT_W-1:0]     count;
  } list_reply_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         command = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [NUM_W-1:0]  item_number = '0;
  logic [NAME_W-1:0]        item_name = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [ST_W-1:0]          status;
  logic signed [NUM_W-1:0]  out_number;
  logic [NAME_W-1:0]        out_name;
  logic [CNT_OUT_W-1:0]     entry_count;

  positional_array_list_unit uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .position    (position),
    .item_number (item_number),
    .item_name   (item_name),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .out_number  (out_number),
    .out_name    (out_name),
    .entry_count (entry_count)
  );

  // shadow copy of the list
  logic signed [NUM_W-1:0] shadow_number [LIST_CAP];
  logic [NAME_W-1:0]       shadow_name [LIST_CAP];
  int                      shadow_len = 0;

  list_cmd_t   cmd_backlog[$];
  list_reply_t replies_due[$];

  int   gen_len = 0;
  int   items_queued = 0;
  int   items_taken = 0;
  logic calm_tail = 1'b0;
  bit   failed = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic apply_list_command(input list_cmd_t c);
    list_reply_t r;
    int slot;
    int k;
    r.status = ST_OK;
    r.number = '0;
    r.name = '0;
    case (c.cmd)
      CMD_CLEAR: shadow_len = 0;
      CMD_INS_AT, CMD_INS_FRONT, CMD_APPEND: begin
        if (shadow_len >= LIST_CAP) begin
          r.status = ST_FULL;
        end else if (c.cmd == CMD_INS_AT && int'(c.pos) >= shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          if (c.cmd == CMD_INS_AT) slot = int'(c.pos);
          else if (c.cmd == CMD_INS_FRONT) slot = 0;
          else slot = shadow_len;
          for (k = shadow_len; k > slot; k--) begin
            shadow_number[k] = shadow_number[k-1];
            shadow_name[k] = shadow_name[k-1];
          end
          shadow_number[slot] = c.number;
          shadow_name[slot] = c.name;
          shadow_len++;
        end
      end
      CMD_DELETE, CMD_READ: begin
        if (int'(c.pos) >= shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          r.number = shadow_number[c.pos];
          r.name = shadow_name[c.pos];
          if (c.cmd == CMD_DELETE) begin
            for (k = int'(c.pos); k + 1 < shadow_len; k++) begin
              shadow_number[k] = shadow_number[k+1];
              shadow_name[k] = shadow_name[k+1];
            end
            shadow_len--;
          end
        end
      end
      default: ;
    endcase
    r.count = shadow_len[CNT_OUT_W-1:0];
    replies_due.push_back(r);
  endtask

  function automatic logic signed [NUM_W-1:0] pick_number();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [NAME_W-1:0] pick_name();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int pick_position();
    if (gen_len == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 63);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return gen_len - 1;
      default: return $urandom_range(0, gen_len - 1);
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(input mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 30) return CMD_APPEND;
        if (r < 55) return CMD_INS_FRONT;
        if (r < 85) return CMD_INS_AT;
        if (r < 93) return CMD_READ;
        if (r < 98) return CMD_DELETE;
        return CMD_SPARE_6;
      end
      MIX_DRAIN: begin
        if (r < 50) return CMD_DELETE;
        if (r < 70) return CMD_READ;
        if (r < 78) return CMD_INS_AT;
        if (r < 84) return CMD_APPEND;
        if (r < 90) return CMD_INS_FRONT;
        if (r < 92) return CMD_CLEAR;
        return CMD_SPARE_7;
      end
      MIX_BLEND: begin
        if (r < 24) return CMD_DELETE;
        if (r < 44) return CMD_INS_AT;
        if (r < 58) return CMD_APPEND;
        if (r < 72) return CMD_INS_FRONT;
        if (r < 94) return CMD_READ;
        if (r < 97) return CMD_CLEAR;
        return (r[0]) ? CMD_SPARE_6 : CMD_SPARE_7;
      end
      default: return CMD_W'($urandom_range(0, 7));
    endcase
  endfunction

  // queue a command and track the list length it leaves behind
  task automatic queue_command(input logic [CMD_W-1:0] cmd, input int pos,
                               input logic signed [NUM_W-1:0] number,
                               input logic [NAME_W-1:0] name);
    list_cmd_t c;
    c.cmd = cmd;
    c.pos = pos[POS_W-1:0];
    c.number = number;
    c.name = name;
    cmd_backlog.push_back(c);
    items_queued++;
    case (cmd)
      CMD_CLEAR: gen_len = 0;
      CMD_INS_AT: if (gen_len < LIST_CAP && pos < gen_len) gen_len++;
      CMD_INS_FRONT, CMD_APPEND: if (gen_len < LIST_CAP) gen_len++;
      CMD_DELETE: if (pos < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int n;
    int seg_len;
    int r;
    bit first_seg;
    mix_t mix;

    // empty list corner cases
    queue_command(CMD_READ, 0, pick_number(), pick_name());
    queue_command(CMD_DELETE, 0, pick_number(), pick_name());
    queue_command(CMD_INS_AT, 0, pick_number(), pick_name());
    queue_command(CMD_APPEND, 0, 32'sh7fffffff, '1);
    queue_command(CMD_INS_FRONT, 63, 32'sh80000000, '0);
    queue_command(CMD_INS_AT, 1, pick_number(), pick_name());
    queue_command(CMD_APPEND, 17, pick_number(), pick_name());
    queue_command(CMD_READ, 0, pick_number(), pick_name());
    queue_command(CMD_READ, 3, pick_number(), pick_name());
    queue_command(CMD_READ, 4, pick_number(), pick_name());
    queue_command(CMD_READ, 63, pick_number(), pick_name());
    queue_command(CMD_INS_AT, 3, '1, 64'h0123456789abcdef);
    queue_command(CMD_DELETE, 4, pick_number(), pick_name());
    queue_command(CMD_DELETE, 0, pick_number(), pick_name());
    queue_command(CMD_DELETE, 63, pick_number(), pick_name());
    queue_command(CMD_SPARE_6, 2, pick_number(), pick_name());
    queue_command(CMD_SPARE_7, 63, '1, '1);
    queue_command(CMD_CLEAR, 63, '1, '1);
    queue_command(CMD_READ, 0, pick_number(), pick_name());
    queue_command(CMD_APPEND, 0, '1, 64'hfedcba9876543210);
    queue_command(CMD_READ, 0, '0, '0);

    // random segments, the first one fills the list to capacity
    n = 0;
    first_seg = 1'b1;
    while (n < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (first_seg) mix = MIX_FILL;
      else if (r < 3) mix = MIX_FILL;
      else if (r < 6) mix = MIX_DRAIN;
      else if (r < 9) mix = MIX_BLEND;
      else mix = MIX_NOISE;
      seg_len = first_seg ? 90 : $urandom_range(30, 120);
      first_seg = 1'b0;
      repeat (seg_len) begin
        if (mix == MIX_NOISE)
          queue_command(CMD_W'($urandom_range(0, 7)), $urandom_range(0, 63),
                        pick_number(), pick_name());
        else
          queue_command(pick_command(mix), pick_position(), pick_number(), pick_name());
        n++;
      end
    end

    while (items_taken != items_queued) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("positional_array_list_unit test passed");
    end else begin
      $display("positional_array_list_unit test failed");
    end
    $finish;
  end

  always @(posedge clk) begin : drive_cmds
    list_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        c.cmd = command;
        c.pos = position;
        c.number = item_number;
        c.name = item_name;
        apply_list_command(c);
        items_taken <= items_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          c = cmd_backlog.pop_front();
          command <= c.cmd;
          position <= c.pos;
          item_number <= c.number;
          item_name <= c.name;
          in_valid <= 1'b1;
          if (cmd_backlog.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0)
            send_gap = $urandom_range(1, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
      calm_tail <= (cmd_backlog.size() <= TAIL_ITEMS);
    end
  end

  always @(posedge clk) begin : check_replies
    list_reply_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $error("result transfer with no command outstanding");
          failed = 1'b1;
        end else begin
          e = replies_due.pop_front();
          if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            failed = 1'b1;
          end
          if (out_number !== e.number) begin
            $error("out_number: expected %0d, got %0d", e.number, out_number);
            failed = 1'b1;
          end
          if (out_name !== e.name) begin
            $error("out_name: expected %h, got %h", e.name, out_name);
            failed = 1'b1;
          end
          if (entry_count !== e.count) begin
            $error("entry_count: expected %0d, got %0d", e.count, entry_count);
            failed = 1'b1;
          end
        end
      end
      // one long hold so the block backs up into its input
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && items_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("positional_array_list_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
